// ----- sv/psba_pkg.sv -----
// Shared types, constants and codes for the per-source byte accounting block.
package psba_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] MIN_ETH_LEN   = 16'd14;
  localparam logic [15:0] MIN_IPV4_LEN  = 16'd34;
  localparam logic [15:0] MIN_IPV6_LEN  = 16'd54;

  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_UPDATED = 2'd1;
  localparam logic [1:0] OUT_NEW     = 2'd2;
  localparam logic [1:0] OUT_FULL    = 2'd3;

  localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [15:0] ip_total_len;
  } desc_t;

  typedef struct packed {
    logic        verdict;
    logic [1:0]  outcome;
    logic [63:0] byte_total;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

endpackage

// ----- sv/per_source_byte_accounting_top.sv -----
// Top level: descriptor classifier, hashed source table and count sequencer.
//
//  channel  | direction | payload         | handshake
//  ---------+-----------+-----------------+------------------------------
//  desc     | in        | psba_pkg::desc_t   | desc_valid / desc_ready
//  result   | out       | psba_pkg::result_t | result_valid / result_ready
//
// Uncounted descriptor: IDLE, PUSH. New entry: IDLE, HASH1, HASH2, LOAD, CMP, PUSH.
// Existing entry: ADD between CMP and PUSH. Each extra probe of the linear-probing
// tag table stays in CMP (one tag RAM read per cycle); a full table with an absent
// key probes all CAPACITY slots. After reset the tag RAM is cleared one slot per cycle,
// with desc_ready low. One descriptor at a time; a stalled result holds the next
// finished result in the sequencer until the output register frees.
module per_source_byte_accounting_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  output logic              desc_ready,
  input  psba_pkg::desc_t   desc,
  output logic              result_valid,
  input  logic              result_ready,
  output psba_pkg::result_t result
);
  import psba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH1 = 3'd2;
  localparam logic [2:0] S_HASH2 = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0]       state;
  desc_t            item;
  result_t          res;
  logic [IDX_W-1:0] probe_idx;
  logic [IDX_W-1:0] next_idx;
  logic [CNT_W-1:0] probes;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] hash_idx;

  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  tag_t             tag_wdata;
  logic [IDX_W-1:0] tag_raddr;
  tag_t             tag_rdata;
  logic             count_we;
  logic [63:0]      count_wdata;
  logic [63:0]      count_rdata;
  logic [63:0]      sum;
  logic             hit;
  logic             is_counted;
  logic             is_dropped;

  psba_hash u_hash (
    .clk (clk),
    .key (item.src_addr),
    .idx (hash_idx)
  );

  psba_ram #(.WIDTH(TAG_W), .DEPTH(CAPACITY)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  psba_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (probe_idx),
    .wdata (count_wdata),
    .raddr (probe_idx),
    .rdata (count_rdata)
  );

  assign desc_ready = (state == S_IDLE);
  assign next_idx   = (probe_idx == IDX_W'(CAPACITY - 1)) ? '0 : probe_idx + 1'b1;
  assign hit        = tag_rdata.valid && (tag_rdata.key == item.src_addr);
  assign sum        = count_rdata + 64'(item.ip_total_len);
  assign is_counted = (desc.frame_len >= MIN_ETH_LEN) && (desc.ether_type == ETH_TYPE_IPV4) &&
                      (desc.frame_len >= MIN_IPV4_LEN);
  assign is_dropped = (desc.frame_len >= MIN_ETH_LEN) && (desc.ether_type == ETH_TYPE_IPV6) &&
                      (desc.frame_len >= MIN_IPV6_LEN);

  always_comb begin
    tag_we      = 1'b0;
    tag_waddr   = probe_idx;
    tag_wdata   = '{valid: 1'b1, key: item.src_addr};
    tag_raddr   = probe_idx;
    count_we    = 1'b0;
    count_wdata = sum;
    case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx;
        tag_wdata = '{valid: 1'b0, key: 32'd0};
      end
      S_LOAD: begin
        tag_raddr = hash_idx;
      end
      S_CMP: begin
        tag_raddr = next_idx;
        if (!tag_rdata.valid) begin
          tag_we      = 1'b1;
          count_we    = 1'b1;
          count_wdata = 64'(item.ip_total_len);
        end
      end
      S_ADD: begin
        count_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_PUSH) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (desc_valid) begin
            item  <= desc;
            res   <= '{verdict: is_dropped, outcome: OUT_NONE, byte_total: 64'd0};
            state <= is_counted ? S_HASH1 : S_PUSH;
          end
        end
        S_HASH1: state <= S_HASH2;
        S_HASH2: state <= S_LOAD;
        S_LOAD: begin
          probe_idx <= hash_idx;
          probes    <= '0;
          state     <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            state <= S_ADD;
          end else if (!tag_rdata.valid) begin
            res.outcome    <= OUT_NEW;
            res.byte_total <= 64'(item.ip_total_len);
            state          <= S_PUSH;
          end else if (probes == CNT_W'(CAPACITY - 1)) begin
            res.outcome <= OUT_FULL;
            state       <= S_PUSH;
          end else begin
            probes    <= probes + 1'b1;
            probe_idx <= next_idx;
          end
        end
        S_ADD: begin
          res.outcome    <= OUT_UPDATED;
          res.byte_total <= sum;
          state          <= S_PUSH;
        end
        S_PUSH: begin
          if (!result_valid || result_ready) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (probes < CNT_W'(CAPACITY)))
    else $error("probe count past table size");

  a_insert_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && tag_we) |=> (state == S_PUSH && res.outcome == OUT_NEW))
    else $error("insert did not finish the transfer");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_PUSH))
    else $error("result raised outside push");

  a_uncounted_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.outcome == OUT_NONE || result.outcome == OUT_FULL))
      |-> (result.byte_total == 64'd0))
    else $error("uncounted result carries a byte total");

  a_drop_uncounted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.verdict) |-> (result.outcome == OUT_NONE))
    else $error("dropped frame was counted");

endmodule

// ----- sv/psba_ram.sv -----
// Generic simple dual-port RAM with registered read.
module psba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/psba_hash.sv -----
// Two-stage hash of the source address into a table slot below CAPACITY.
module psba_hash (
  input  logic                     clk,
  input  logic [31:0]              key,
  output logic [psba_pkg::IDX_W-1:0] idx
);
  import psba_pkg::*;

  logic [63:0]        mix_prod;
  logic [31:0]        mix;
  logic [15+CNT_W:0]  range_prod;

  assign mix_prod   = 64'(key) * 64'(HASH_MULT);
  assign range_prod = (16 + CNT_W)'(mix[31:16]) * (16 + CNT_W)'(CAPACITY);

  always_ff @(posedge clk) begin
    mix <= mix_prod[31:0];
    idx <= range_prod[16 +: IDX_W];
  end

endmodule

// ----- test/tb_per_source_byte_accounting_top.sv -----
// Testbench for per_source_byte_accounting_top: directed, mixed, fill and full-table traffic.
module tb_per_source_byte_accounting_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psba_pkg::*;

  localparam int STALL_LIMIT = 50000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    desc_valid = 1'b0;
  logic    desc_ready;
  desc_t   desc = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  per_source_byte_accounting_top uut (
    .clk          (clk),
    .rst          (rst),
    .desc_valid   (desc_valid),
    .desc_ready   (desc_ready),
    .desc         (desc),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the source table.
  int          slot_of [logic [31:0]];
  logic [63:0] byte_count [CAPACITY];
  logic [31:0] known_keys [$];
  int          occupied = 0;

  result_t pending_results [$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 1'b0;

  function automatic result_t account_frame(input desc_t d);
    result_t r;
    int      slot;
    r = '0;
    slot = 0;
    if (d.ether_type == ETH_TYPE_IPV4 && d.frame_len >= MIN_IPV4_LEN) begin
      if (slot_of.exists(d.src_addr)) begin
        slot = slot_of[d.src_addr];
        r.outcome = OUT_UPDATED;
      end else if (occupied < CAPACITY) begin
        slot = occupied;
        slot_of[d.src_addr] = slot;
        byte_count[slot] = '0;
        known_keys.push_back(d.src_addr);
        occupied++;
        r.outcome = OUT_NEW;
      end else begin
        r.outcome = OUT_FULL;
      end
      if (r.outcome != OUT_FULL) begin
        byte_count[slot] = byte_count[slot] + 64'(d.ip_total_len);
        r.byte_total = byte_count[slot];
      end
    end else if (d.ether_type == ETH_TYPE_IPV6 && d.frame_len >= MIN_IPV6_LEN) begin
      r.verdict = 1'b1;
    end
    return r;
  endfunction

  task automatic push_desc(input logic [15:0] flen, etype, input logic [31:0] src,
                           input logic [15:0] tlen);
    desc_t d;
    d = '{flen, etype, src, tlen};
    if (!no_gaps) begin
      while ($urandom_range(99) < 12) begin
        desc_valid <= 1'b0;
        @(posedge clk);
      end
    end
    desc <= d;
    desc_valid <= 1'b1;
    do @(posedge clk); while (!desc_ready);
    pending_results.push_back(account_frame(d));
  endtask

  function automatic logic [31:0] pick_key(input int reuse_pct);
    if (known_keys.size() > 0 && $urandom_range(99) < reuse_pct)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    do k = $urandom; while (slot_of.exists(k));
    return k;
  endfunction

  function automatic logic [15:0] ipv4_len();
    return ($urandom_range(9) == 0) ? 16'($urandom_range(34, 65535))
                                    : 16'($urandom_range(34, 1518));
  endfunction

  // Non-counting traffic: IPv6 around its threshold, short IPv4, other types.
  task automatic push_noise();
    int r;
    r = $urandom_range(99);
    if (r < 35)
      push_desc(($urandom_range(1) != 0) ? 16'($urandom_range(40, 70)) : 16'($urandom),
                ETH_TYPE_IPV6, $urandom, 16'($urandom));
    else if (r < 65)
      push_desc(16'($urandom_range(0, 33)), ETH_TYPE_IPV4, pick_key(50), 16'($urandom));
    else
      push_desc(16'($urandom), 16'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic test_directed();
    push_desc(16'd0,     ETH_TYPE_IPV4, 32'h0000_0000, 16'hFFFF);
    push_desc(16'd13,    ETH_TYPE_IPV4, 32'hFFFF_FFFF, 16'hFFFF);
    push_desc(16'd14,    ETH_TYPE_IPV4, 32'h0000_0000, 16'hFFFF);
    push_desc(16'd33,    ETH_TYPE_IPV4, 32'h0000_0000, 16'hFFFF);
    push_desc(16'd34,    ETH_TYPE_IPV4, 32'h0000_0000, 16'h0000);
    push_desc(16'd34,    ETH_TYPE_IPV4, 32'h0000_0000, 16'hFFFF);
    push_desc(16'hFFFF,  ETH_TYPE_IPV4, 32'hFFFF_FFFF, 16'hFFFF);
    push_desc(16'hFFFF,  ETH_TYPE_IPV4, 32'hFFFF_FFFF, 16'hFFFF);
    push_desc(16'd60,    ETH_TYPE_IPV4, 32'h0000_0000, 16'd1);
    push_desc(16'd13,    ETH_TYPE_IPV6, 32'h0000_0000, 16'd0);
    push_desc(16'd14,    ETH_TYPE_IPV6, 32'h0000_0000, 16'd0);
    push_desc(16'd53,    ETH_TYPE_IPV6, 32'h0000_0000, 16'd0);
    push_desc(16'd54,    ETH_TYPE_IPV6, 32'h0000_0000, 16'd0);
    push_desc(16'hFFFF,  ETH_TYPE_IPV6, 32'hFFFF_FFFF, 16'hFFFF);
    push_desc(16'hFFFF,  16'h0000,      32'h0000_0000, 16'hFFFF);
    push_desc(16'hFFFF,  16'hFFFF,      32'hFFFF_FFFF, 16'hFFFF);
    push_desc(16'hFFFF,  16'h0801,      32'h0000_0000, 16'hFFFF);
    push_desc(16'hFFFF,  16'h07FF,      32'h0000_0000, 16'hFFFF);
    push_desc(16'hFFFF,  16'h86DC,      32'h0000_0000, 16'hFFFF);
    push_desc(16'hFFFF,  16'h86DE,      32'h0000_0000, 16'hFFFF);
    push_desc(16'd0,     16'h0000,      32'h0000_0000, 16'h0000);
  endtask

  task automatic test_mixed_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 3) && (i < 2 * n / 3);
      if ($urandom_range(99) < 60)
        push_desc(ipv4_len(), ETH_TYPE_IPV4, pick_key(85), 16'($urandom));
      else
        push_noise();
    end
    no_gaps = 1'b0;
  endtask

  // Fill every slot, then try one more source.
  task automatic test_fill_table();
    while (occupied < CAPACITY) begin
      if ($urandom_range(7) == 0)
        push_desc(ipv4_len(), ETH_TYPE_IPV4, pick_key(100), 16'($urandom));
      else
        push_desc(ipv4_len(), ETH_TYPE_IPV4, fresh_key(), 16'($urandom));
    end
    push_desc(16'd34, ETH_TYPE_IPV4, fresh_key(), 16'hFFFF);
  endtask

  task automatic test_full_table(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60)
        push_desc(ipv4_len(), ETH_TYPE_IPV4, pick_key(100), 16'($urandom));
      else if (r < 65)
        push_desc(ipv4_len(), ETH_TYPE_IPV4, fresh_key(), 16'($urandom));
      else
        push_noise();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_mixed_traffic(220);
    test_fill_table();
    test_full_table(220);
    desc_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst)
      result_ready <= 1'b0;
    else
      result_ready <= no_gaps || ($urandom_range(99) >= 12);
  end

  // Result checking and watchdog.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (result.verdict !== exp_r.verdict) begin
            $error("verdict: expected %0d, got %0d", exp_r.verdict, result.verdict);
            errors++;
          end
          if (result.outcome !== exp_r.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_r.outcome, result.outcome);
            errors++;
          end
          if (result.byte_total !== exp_r.byte_total) begin
            $error("byte_total: expected %0d, got %0d", exp_r.byte_total, result.byte_total);
            errors++;
          end
        end
      end
      if ((result_valid && result_ready) || (desc_valid && desc_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
